// ===== design/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared codes, control word layout and the microprogram of the dual
// shift-chain output driver.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int DSC_CHAIN_BITS = 16;
  localparam int DSC_FIELD_BITS = 16;

  localparam logic [1:0] CMD_BOTH  = 2'd0;
  localparam logic [1:0] CMD_LED   = 2'd1;
  localparam logic [1:0] CMD_RELAY = 2'd2;

  localparam logic [1:0] ACT_OFF = 2'd0;
  localparam logic [1:0] ACT_ON  = 2'd1;

  typedef logic [1:0] dsc_addr_t;

  localparam dsc_addr_t ADDR_BIT_LOW  = 2'd0;
  localparam dsc_addr_t ADDR_BIT_HIGH = 2'd1;
  localparam dsc_addr_t ADDR_LATCH_LO = 2'd2;
  localparam dsc_addr_t ADDR_LATCH_HI = 2'd3;

  // One microinstruction: pin levels for the beat, loop and end flags, and
  // the fall-through address.
  typedef struct packed {
    logic      sclk;
    logic      latch;
    logic      last;
    logic      loop;
    dsc_addr_t next;
  } dsc_uword_t;

  // Control handed from the sequencer to the datapath for one beat.
  typedef struct packed {
    logic sclk;
    logic latch;
    logic last;
    logic shift;
  } dsc_ctrl_t;

  function automatic dsc_uword_t dsc_rom(input dsc_addr_t addr);
    dsc_uword_t uw;
    unique case (addr)
      ADDR_BIT_LOW:  uw = '{sclk: 1'b0, latch: 1'b1, last: 1'b0, loop: 1'b0,
                           next: ADDR_BIT_HIGH};
      ADDR_BIT_HIGH: uw = '{sclk: 1'b1, latch: 1'b1, last: 1'b0, loop: 1'b1,
                           next: ADDR_LATCH_LO};
      ADDR_LATCH_LO: uw = '{sclk: 1'b1, latch: 1'b0, last: 1'b0, loop: 1'b0,
                           next: ADDR_LATCH_HI};
      default:       uw = '{sclk: 1'b1, latch: 1'b1, last: 1'b1, loop: 1'b0,
                           next: ADDR_BIT_LOW};
    endcase
    return uw;
  endfunction

endpackage

// ===== design/dsc_seq.sv =====
// ----------------------------------------------------------------------------
// dsc_seq
// Microcoded step sequencer: a step counter addresses the control ROM, and a
// bit counter decides the conditional jump back to the start of a bit.
// ----------------------------------------------------------------------------
module dsc_seq
  import dsc_pkg::*;
#(
  parameter int CHAIN_BITS = DSC_CHAIN_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      advance,
  output logic      busy,
  output logic      emit,
  output dsc_ctrl_t ctrl
);

  localparam int CW = $clog2(CHAIN_BITS);

  dsc_addr_t  step;
  logic [CW-1:0] cnt;
  dsc_uword_t uw;
  logic       take_jump;

  assign uw        = dsc_rom(step);
  assign emit      = busy && advance;
  assign take_jump = uw.loop && (cnt != '0);

  assign ctrl.sclk  = uw.sclk;
  assign ctrl.latch = uw.latch;
  assign ctrl.last  = uw.last;
  assign ctrl.shift = take_jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ADDR_BIT_LOW;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= ADDR_BIT_LOW;
      cnt  <= CW'(CHAIN_BITS - 1);
    end else if (emit) begin
      if (uw.last) begin
        busy <= 1'b0;
        step <= ADDR_BIT_LOW;
      end else if (take_jump) begin
        step <= ADDR_BIT_LOW;
        cnt  <= cnt - 1'b1;
      end else begin
        step <= uw.next;
      end
    end
  end

  // The latch steps are reached only once every bit has gone out.
  a_latch_after_bits: assert property (@(posedge clk) disable iff (rst)
    busy && (step == ADDR_LATCH_LO || step == ADDR_LATCH_HI) |-> cnt == '0)
    else $error("latch step reached with bits remaining");

  // A new program is never started on top of a running one.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("sequencer restarted while busy");

endmodule

// ===== design/dual_shift_chain_output_driver.sv =====
// ----------------------------------------------------------------------------
// dual_shift_chain_output_driver
// Keeps a relay word and an active-low LED word and drives them out MSB first
// on two serial chains as pin-level beats, followed by a latch pulse.
// ----------------------------------------------------------------------------
// The command beat starts the sequencer, whose steps are registered as beats.
// Throughput: 2*CHAIN_BITS+2 result beats (34 at 16 bits), one per cycle as
// the microprogram steps unless the receiver stalls; the next command is
// taken in the cycle after the last beat leaves the sequencer. Ignored
// commands emit nothing. Reset: synchronous; relay word clears to zero, LED word sets to all ones.
// ----------------------------------------------------------------------------
module dual_shift_chain_output_driver
  import dsc_pkg::*;
#(
  parameter int CHAIN_BITS = DSC_CHAIN_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [1:0]  action,
  input  logic [15:0] relay_mask,
  input  logic [15:0] led_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        relay_data,
  output logic        relay_shift_clk,
  output logic        relay_latch_clk,
  output logic        led_data,
  output logic        led_shift_clk,
  output logic        led_latch_clk,
  output logic [15:0] relay_word,
  output logic [15:0] led_word,
  output logic        last
);

  localparam int EXT = CHAIN_BITS + DSC_FIELD_BITS;

  logic [CHAIN_BITS-1:0] relay_bits, relay_bits_next;
  logic [CHAIN_BITS-1:0] led_bits, led_bits_next;
  logic [CHAIN_BITS-1:0] relay_sr, led_sr;
  logic [CHAIN_BITS-1:0] rmask, lmask;
  logic [EXT-1:0]        rmask_ext, lmask_ext, rword_ext, lword_ext;
  logic                  relay_on, led_on;
  logic                  cmd_relay, cmd_led, cmd_ok;
  logic                  in_take, start, busy, emit, advance;
  dsc_ctrl_t             ctrl;

  assign rmask_ext = {{CHAIN_BITS{1'b0}}, relay_mask};
  assign lmask_ext = {{CHAIN_BITS{1'b0}}, led_mask};
  assign rmask     = rmask_ext[CHAIN_BITS-1:0];
  assign lmask     = lmask_ext[CHAIN_BITS-1:0];

  always_comb begin
    cmd_relay = 1'b0;
    cmd_led   = 1'b0;
    case (command)
      CMD_BOTH: begin
        cmd_relay = 1'b1;
        cmd_led   = 1'b1;
      end
      CMD_LED:   cmd_led   = 1'b1;
      CMD_RELAY: cmd_relay = 1'b1;
      default: ;
    endcase
    cmd_ok = (cmd_relay || cmd_led) && (action == ACT_ON || action == ACT_OFF);

    relay_bits_next = relay_bits;
    led_bits_next   = led_bits;
    if (action == ACT_ON) begin
      if (cmd_relay) relay_bits_next = relay_bits | rmask;
      if (cmd_led)   led_bits_next   = led_bits & lmask;
    end else begin
      if (cmd_relay) relay_bits_next = relay_bits & ~rmask;
      if (cmd_led)   led_bits_next   = led_bits | ~lmask;
    end
  end

  assign in_ready = !busy;
  assign in_take  = in_valid && in_ready;
  assign start    = in_take && cmd_ok;
  assign advance  = !out_valid || out_ready;

  dsc_seq #(.CHAIN_BITS(CHAIN_BITS)) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .advance (advance),
    .busy    (busy),
    .emit    (emit),
    .ctrl    (ctrl)
  );

  assign rword_ext = {{DSC_FIELD_BITS{1'b0}}, relay_bits};
  assign lword_ext = {{DSC_FIELD_BITS{1'b0}}, led_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_bits <= '0;
      led_bits   <= '1;
      out_valid  <= 1'b0;
    end else begin
      if (start) begin
        relay_bits <= relay_bits_next;
        led_bits   <= led_bits_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Shift registers and the output beat register carry payload only.
  always_ff @(posedge clk) begin
    if (start) begin
      relay_sr <= relay_bits_next;
      led_sr   <= led_bits_next;
      relay_on <= cmd_relay;
      led_on   <= cmd_led;
    end else if (emit && ctrl.shift) begin
      relay_sr <= relay_sr << 1;
      led_sr   <= led_sr << 1;
    end
    if (emit) begin
      // An untouched chain idles at data low with both clocks high.
      relay_data      <= relay_on && relay_sr[CHAIN_BITS-1];
      relay_shift_clk <= relay_on ? ctrl.sclk : 1'b1;
      relay_latch_clk <= relay_on ? ctrl.latch : 1'b1;
      led_data        <= led_on && led_sr[CHAIN_BITS-1];
      led_shift_clk   <= led_on ? ctrl.sclk : 1'b1;
      led_latch_clk   <= led_on ? ctrl.latch : 1'b1;
      relay_word      <= rword_ext[DSC_FIELD_BITS-1:0];
      led_word        <= lword_ext[DSC_FIELD_BITS-1:0];
      last            <= ctrl.last;
    end
  end

  a_start_blocks_input: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input still ready after a command started");

  a_last_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> relay_shift_clk && relay_latch_clk &&
                          led_shift_clk && led_latch_clk)
    else $error("final beat does not leave the pins high");

  a_latch_with_sclk: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!relay_latch_clk || !led_latch_clk) |->
      relay_shift_clk && led_shift_clk)
    else $error("latch pulse while shift clock is low");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    in_take && !cmd_ok |=> in_ready)
    else $error("ignored command started the sequencer");

endmodule

// ===== dv/tb_dual_shift_chain_output_driver.sv =====
// ----------------------------------------------------------------------------
// tb_dual_shift_chain_output_driver
// Self-checking bench for the dual shift-chain output driver. Command beats
// from a queue drive the block. A local model of the relay and LED words
// predicts every pin beat of each serial sequence. A monitor compares each
// output beat field by field in order. Phases vary sender idling and receiver
// stalls, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_dual_shift_chain_output_driver;
  import dsc_pkg::*;

  // Codes the block ignores; it produces no beats for them.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ACT_NOP2   = 2'd2;
  localparam logic [1:0] ACT_NOP3   = 2'd3;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_STALL  = 300;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  action;
    logic [15:0] relay_mask;
    logic [15:0] led_mask;
  } chain_cmd_t;

  typedef struct packed {
    logic        relay_data;
    logic        relay_shift_clk;
    logic        relay_latch_clk;
    logic        led_data;
    logic        led_shift_clk;
    logic        led_latch_clk;
    logic [15:0] relay_word;
    logic [15:0] led_word;
    logic        is_last;
  } pin_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_BOTH;
  logic [1:0]  action = ACT_OFF;
  logic [15:0] relay_mask = '0;
  logic [15:0] led_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        relay_data;
  logic        relay_shift_clk;
  logic        relay_latch_clk;
  logic        led_data;
  logic        led_shift_clk;
  logic        led_latch_clk;
  logic [15:0] relay_word;
  logic [15:0] led_word;
  logic        last;

  chain_cmd_t  pending_cmds[$];
  pin_beat_t   expected_beats[$];

  logic [15:0] relay_img;
  logic [15:0] led_img;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int offered_cnt = 0;
  int taken_cnt = 0;
  int ignored_cnt = 0;
  int beats_checked = 0;
  int errors = 0;
  int cycles = 0;
  int long_stalls_wanted = 0;
  int long_stalls_done = 0;
  int stall_left = 0;

  dual_shift_chain_output_driver i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .action          (action),
    .relay_mask      (relay_mask),
    .led_mask        (led_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .relay_data      (relay_data),
    .relay_shift_clk (relay_shift_clk),
    .relay_latch_clk (relay_latch_clk),
    .led_data        (led_data),
    .led_shift_clk   (led_shift_clk),
    .led_latch_clk   (led_latch_clk),
    .relay_word      (relay_word),
    .led_word        (led_word),
    .last            (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // An untouched chain rests at data 0, shift clock 1, latch 1.
  function automatic pin_beat_t chain_beat(logic relay_on, logic led_on, logic rbit,
                                           logic lbit, logic sclk, logic latch,
                                           logic fin);
    pin_beat_t p;
    p.relay_data      = relay_on ? rbit : 1'b0;
    p.relay_shift_clk = relay_on ? sclk : 1'b1;
    p.relay_latch_clk = relay_on ? latch : 1'b1;
    p.led_data        = led_on ? lbit : 1'b0;
    p.led_shift_clk   = led_on ? sclk : 1'b1;
    p.led_latch_clk   = led_on ? latch : 1'b1;
    p.relay_word      = relay_img;
    p.led_word        = led_img;
    p.is_last         = fin;
    return p;
  endfunction

  // Applies one command to the word images and queues the pin beats it causes.
  task automatic predict_chain_beats(input chain_cmd_t c);
    logic        relay_on;
    logic        led_on;
    logic [15:0] rs;
    logic [15:0] ls;
    logic        rbit;
    logic        lbit;
    if (!(c.action inside {ACT_OFF, ACT_ON}) || c.command == CMD_UNUSED) begin
      ignored_cnt++;
      return;
    end
    relay_on = (c.command == CMD_BOTH) || (c.command == CMD_RELAY);
    led_on   = (c.command == CMD_BOTH) || (c.command == CMD_LED);
    if (c.action == ACT_ON) begin
      if (relay_on) relay_img = relay_img | c.relay_mask;
      if (led_on) led_img = led_img & c.led_mask;
    end else begin
      if (relay_on) relay_img = relay_img & ~c.relay_mask;
      if (led_on) led_img = led_img | ~c.led_mask;
    end
    rs = relay_img;
    ls = led_img;
    rbit = 1'b0;
    lbit = 1'b0;
    for (int i = 0; i < DSC_CHAIN_BITS; i++) begin
      rbit = rs[15];
      lbit = ls[15];
      expected_beats.push_back(chain_beat(relay_on, led_on, rbit, lbit, 1'b0, 1'b1, 1'b0));
      expected_beats.push_back(chain_beat(relay_on, led_on, rbit, lbit, 1'b1, 1'b1, 1'b0));
      rs = rs << 1;
      ls = ls << 1;
    end
    // Latch pulse: data holds the LSB that went out last.
    expected_beats.push_back(chain_beat(relay_on, led_on, rbit, lbit, 1'b1, 1'b0, 1'b0));
    expected_beats.push_back(chain_beat(relay_on, led_on, rbit, lbit, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Command driver: a new beat is offered only after the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || offered_cnt == taken_cnt) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        chain_cmd_t c;
        c = pending_cmds.pop_front();
        command    <= c.command;
        action     <= c.action;
        relay_mask <= c.relay_mask;
        led_mask   <= c.led_mask;
        in_valid   <= 1'b1;
        offered_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pin-beat receiver, with an occasional long hold-off counted here.
  always @(negedge clk) begin
    if (long_stalls_wanted != long_stalls_done) begin
      stall_left = LONG_STALL;
      long_stalls_done++;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pin_beat_t got;
    pin_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_chain_beats('{command: command, action: action,
                              relay_mask: relay_mask, led_mask: led_mask});
        taken_cnt++;
      end
      if (out_valid && out_ready) begin
        got = '{relay_data: relay_data, relay_shift_clk: relay_shift_clk,
                relay_latch_clk: relay_latch_clk, led_data: led_data,
                led_shift_clk: led_shift_clk, led_latch_clk: led_latch_clk,
                relay_word: relay_word, led_word: led_word, is_last: last};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected pin beat, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("relay_data", 16'(want.relay_data), 16'(got.relay_data));
          check_field("relay_shift_clk", 16'(want.relay_shift_clk),
                      16'(got.relay_shift_clk));
          check_field("relay_latch_clk", 16'(want.relay_latch_clk),
                      16'(got.relay_latch_clk));
          check_field("led_data", 16'(want.led_data), 16'(got.led_data));
          check_field("led_shift_clk", 16'(want.led_shift_clk), 16'(got.led_shift_clk));
          check_field("led_latch_clk", 16'(want.led_latch_clk), 16'(got.led_latch_clk));
          check_field("relay_word", want.relay_word, got.relay_word);
          check_field("led_word", want.led_word, got.led_word);
          check_field("last", 16'(want.is_last), 16'(got.is_last));
        end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats still expected", $time, expected_beats.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] pick_mask();
    logic [15:0] m;
    case ($urandom_range(9))
      0: m = 16'h0000;
      1: m = 16'hFFFF;
      2: m = 16'h0001 << $urandom_range(15);
      3: m = ~(16'h0001 << $urandom_range(15));
      default: m = 16'($urandom());
    endcase
    return m;
  endfunction

  task automatic add_cmd(input logic [1:0] cmd, input logic [1:0] act,
                         input logic [15:0] rmask, input logic [15:0] lmask);
    pending_cmds.push_back('{command: cmd, action: act, relay_mask: rmask,
                             led_mask: lmask});
  endtask

  // Mostly well-formed commands; about one in ten is an ignored code.
  task automatic add_random_cmds(input int count);
    int n;
    logic [1:0] cmd;
    logic [1:0] act;
    n = 0;
    while (n < count) begin
      cmd = 2'($urandom_range(2));
      act = 2'($urandom_range(1));
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) cmd = CMD_UNUSED;
        else act = $urandom_range(1) ? ACT_NOP2 : ACT_NOP3;
      end else begin
        n++;
      end
      add_cmd(cmd, act, pick_mask(), pick_mask());
    end
  endtask

  // Waits until every queued command is taken and every beat seen.
  task automatic drain();
    while (pending_cmds.size() > 0 || offered_cnt != taken_cnt || in_valid ||
           expected_beats.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random_cmds(count);
    drain();
  endtask

  initial begin
    relay_img = 16'h0000;
    led_img = 16'hFFFF;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: mask extremes, single end bits, every command and action,
    // ignored actions and the unknown command.
    add_cmd(CMD_BOTH, ACT_ON, 16'hFFFF, 16'h0000);
    add_cmd(CMD_BOTH, ACT_OFF, 16'hFFFF, 16'h0000);
    add_cmd(CMD_RELAY, ACT_ON, 16'h8000, 16'h1234);
    add_cmd(CMD_RELAY, ACT_ON, 16'h0001, 16'h0000);
    add_cmd(CMD_LED, ACT_ON, 16'hFFFF, 16'h7FFE);
    add_cmd(CMD_LED, ACT_OFF, 16'h0000, 16'h0001);
    add_cmd(CMD_RELAY, ACT_OFF, 16'h8000, 16'hFFFF);
    add_cmd(CMD_BOTH, ACT_ON, 16'hA5A5, 16'h5A5A);
    add_cmd(CMD_BOTH, ACT_OFF, 16'h0F0F, 16'hF0F0);
    add_cmd(CMD_BOTH, ACT_NOP2, 16'hFFFF, 16'h0000);
    add_cmd(CMD_LED, ACT_NOP3, 16'hFFFF, 16'h0000);
    add_cmd(CMD_UNUSED, ACT_ON, 16'hFFFF, 16'h0000);
    add_cmd(CMD_UNUSED, ACT_OFF, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_RELAY, ACT_ON, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_LED, ACT_ON, 16'h0000, 16'hFFFF);
    add_cmd(CMD_LED, ACT_ON, 16'hFFFF, 16'h0000);
    add_cmd(CMD_BOTH, ACT_OFF, 16'h0000, 16'hFFFF);
    add_cmd(CMD_BOTH, ACT_OFF, 16'hFFFF, 16'h0000);
    drain();

    run_phase(70, 0, 20);
    run_phase(0, 70, 20);
    run_phase(38, 38, 20);

    // Long receiver hold-off while the sender keeps offering back to back.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_stalls_wanted++;
    add_random_cmds(10);
    drain();

    run_phase(0, 0, 10);
    repeat (40) @(posedge clk);

    $display("Accepted %0d commands (%0d ignored) and checked %0d pin beats,",
             taken_cnt, ignored_cnt, beats_checked);
    $display("across idle, stall, mixed and long output hold-off phases.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
